### hw/rtl/lbpe_pkg.sv
// ----------------------------------------------------------------------------
// LED bar-graph encoder package
// Shared sizes, register indexes, selector codes and pipeline payload types.
// ----------------------------------------------------------------------------
package lbpe_pkg;

  localparam int MAX_LEDS    = 64;
  localparam int LEVEL_BITS  = 16;
  localparam int LED_W       = $clog2(MAX_LEDS + 1);
  localparam int NBYTES      = (MAX_LEDS + 7) / 8;
  localparam int IMG_W       = 8 * NBYTES;
  localparam int BC_W        = $clog2(NBYTES + 1);
  localparam int QW          = LED_W;
  localparam int NUM_W       = LEVEL_BITS + LED_W;
  localparam int LEDS_REG_W  = 7;
  localparam int NUM_REGS    = 6;
  localparam int IDX_W       = $clog2(NUM_REGS);
  localparam int ADDR_W      = IDX_W + 2;
  localparam int DATA_W      = 32;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE       = 0,
    REG_RANGE_LOW  = 1,
    REG_RANGE_HIGH = 2,
    REG_LEDS       = 3,
    REG_REVERSE    = 4,
    REG_ENABLE     = 5
  } reg_idx_t;

  // How the quotient finishes the lit range
  typedef enum logic [1:0] {
    SEL_NONE  = 2'd0,
    SEL_CNT   = 2'd1,
    SEL_RIGHT = 2'd2,
    SEL_LEFT  = 2'd3
  } sel_t;

  typedef struct packed {
    logic                         display_mode;
    logic signed [LEVEL_BITS-1:0] range_low;
    logic signed [LEVEL_BITS-1:0] range_high;
    logic                         reverse_order;
    logic                         output_enable;
    logic [LED_W-1:0]             n;
    logic [BC_W-1:0]              bc;
  } cfg_t;

  // Lit LEDs are lo_idx <= i < hi_ex
  typedef struct packed {
    sel_t                  sel;
    logic [LED_W-1:0]      lo_idx;
    logic [LED_W-1:0]      hi_ex;
    logic [LEVEL_BITS-1:0] mul_a;
    logic [LED_W-1:0]      mul_b;
    logic [LEVEL_BITS-1:0] den;
    logic                  ceil_up;
  } prep_t;

  typedef struct packed {
    sel_t                  sel;
    logic [LED_W-1:0]      lo_idx;
    logic [LED_W-1:0]      hi_ex;
    logic [NUM_W-1:0]      rem;
    logic [LEVEL_BITS-1:0] den;
    logic [QW-1:0]         q;
  } div_t;

  typedef struct packed {
    sel_t             sel;
    logic [LED_W-1:0] lo_idx;
    logic [LED_W-1:0] hi_ex;
    logic [QW-1:0]    q;
  } span_t;

endpackage

### hw/rtl/lbpe_if.sv
// ----------------------------------------------------------------------------
// LED bar-graph encoder stream interfaces
// Valid/ready channels for the level input and the shift image result.
// ----------------------------------------------------------------------------
interface lbpe_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [lbpe_pkg::LEVEL_BITS-1:0] level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

interface lbpe_out_if;
  logic                           valid;
  logic                           ready;
  logic [lbpe_pkg::IMG_W-1:0]     shift_image;
  logic [lbpe_pkg::BC_W-1:0]      byte_count;

  modport source (output valid, output shift_image, output byte_count, input ready);
  modport sink   (input valid, input shift_image, input byte_count, output ready);
endinterface

### hw/rtl/lbpe_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file; also derives the effective LED and byte counts.
// ----------------------------------------------------------------------------
module lbpe_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lbpe_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [lbpe_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [lbpe_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  output lbpe_pkg::cfg_t                cfg
);

  logic                                   mode_r;
  logic signed [lbpe_pkg::LEVEL_BITS-1:0] range_low_r;
  logic signed [lbpe_pkg::LEVEL_BITS-1:0] range_high_r;
  logic [lbpe_pkg::LEDS_REG_W-1:0]        leds_r;
  logic                                   reverse_r;
  logic                                   enable_r;
  logic                                   wr_en;
  lbpe_pkg::reg_idx_t                     idx;
  logic [lbpe_pkg::LED_W-1:0]             n_eff;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = lbpe_pkg::reg_idx_t'(cfg_paddr[lbpe_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b0;
      range_low_r  <= '0;
      range_high_r <= lbpe_pkg::LEVEL_BITS'(64);
      leds_r       <= lbpe_pkg::LEDS_REG_W'(64);
      reverse_r    <= 1'b0;
      enable_r     <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        lbpe_pkg::REG_MODE:       mode_r       <= cfg_pwdata[0];
        lbpe_pkg::REG_RANGE_LOW:  range_low_r  <= cfg_pwdata[lbpe_pkg::LEVEL_BITS-1:0];
        lbpe_pkg::REG_RANGE_HIGH: range_high_r <= cfg_pwdata[lbpe_pkg::LEVEL_BITS-1:0];
        lbpe_pkg::REG_LEDS:       leds_r       <= cfg_pwdata[lbpe_pkg::LEDS_REG_W-1:0];
        lbpe_pkg::REG_REVERSE:    reverse_r    <= cfg_pwdata[0];
        lbpe_pkg::REG_ENABLE:     enable_r     <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lbpe_pkg::REG_MODE:       cfg_prdata = lbpe_pkg::DATA_W'(mode_r);
      lbpe_pkg::REG_RANGE_LOW:  cfg_prdata = lbpe_pkg::DATA_W'($unsigned(range_low_r));
      lbpe_pkg::REG_RANGE_HIGH: cfg_prdata = lbpe_pkg::DATA_W'($unsigned(range_high_r));
      lbpe_pkg::REG_LEDS:       cfg_prdata = lbpe_pkg::DATA_W'(leds_r);
      lbpe_pkg::REG_REVERSE:    cfg_prdata = lbpe_pkg::DATA_W'(reverse_r);
      lbpe_pkg::REG_ENABLE:     cfg_prdata = lbpe_pkg::DATA_W'(enable_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  // Zero LEDs acts as one, anything above the maximum as the maximum
  always_comb begin
    if (leds_r == '0) begin
      n_eff = lbpe_pkg::LED_W'(1);
    end else if (leds_r > lbpe_pkg::LEDS_REG_W'(lbpe_pkg::MAX_LEDS)) begin
      n_eff = lbpe_pkg::LED_W'(lbpe_pkg::MAX_LEDS);
    end else begin
      n_eff = leds_r[lbpe_pkg::LED_W-1:0];
    end
  end

  always_comb begin
    cfg.display_mode  = mode_r;
    cfg.range_low     = range_low_r;
    cfg.range_high    = range_high_r;
    cfg.reverse_order = reverse_r;
    cfg.output_enable = enable_r;
    cfg.n             = n_eff;
    cfg.bc            = lbpe_pkg::BC_W'(({1'b0, n_eff} + (lbpe_pkg::LED_W + 1)'(7)) >> 3);
  end

endmodule

### hw/rtl/lbpe_prep.sv
// ----------------------------------------------------------------------------
// Operand preparation
// Stage 1 classifies the level and picks divider operands; stage 2 forms the
// scaled numerator with the ceiling offset.
// ----------------------------------------------------------------------------
module lbpe_prep (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  lbpe_pkg::cfg_t                         cfg,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [lbpe_pkg::LEVEL_BITS-1:0] in_level,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output lbpe_pkg::div_t                         out_data
);

  localparam int SW = lbpe_pkg::LEVEL_BITS + 1;
  localparam int LB = lbpe_pkg::LEVEL_BITS;
  localparam int LW = lbpe_pkg::LED_W;

  logic                  s1_valid_r;
  lbpe_pkg::prep_t       s1_data_r;
  lbpe_pkg::prep_t       s1_data_nxt;
  logic                  s1_ready;
  logic                  s2_valid_r;
  lbpe_pkg::div_t        s2_data_r;
  lbpe_pkg::div_t        s2_data_nxt;
  logic                  s2_ready;

  logic signed [SW-1:0]  v;
  logic signed [SW-1:0]  lo;
  logic signed [SW-1:0]  hi;
  logic signed [SW-1:0]  nn;
  logic signed [SW-1:0]  diff_vl;
  logic signed [SW-1:0]  diff_hl;
  logic signed [SW-1:0]  neg_v;
  logic signed [SW-1:0]  neg_lo;
  logic [LW-1:0]         lc;
  logic [LW-1:0]         rc;
  logic [lbpe_pkg::NUM_W-1:0] prod;
  logic [lbpe_pkg::NUM_W-1:0] offs;

  assign s2_ready  = !s2_valid_r || out_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_ready  = s1_ready;
  assign out_valid = s2_valid_r;
  assign out_data  = s2_data_r;

  always_comb begin
    v       = {in_level[LB-1], in_level};
    lo      = {cfg.range_low[LB-1], cfg.range_low};
    hi      = {cfg.range_high[LB-1], cfg.range_high};
    nn      = {{(SW-LW){1'b0}}, cfg.n};
    diff_vl = v - lo;
    diff_hl = hi - lo;
    neg_v   = -v;
    neg_lo  = -lo;
    lc      = LW'((cfg.n - 1'b1) >> 1);
    rc      = LW'(cfg.n >> 1);

    s1_data_nxt         = '0;
    s1_data_nxt.sel     = lbpe_pkg::SEL_NONE;
    s1_data_nxt.den     = LB'(1);

    if (!cfg.display_mode) begin
      if ((lo != 0 || hi != nn) && hi > lo) begin
        if (v <= lo) begin
          s1_data_nxt.hi_ex = '0;
        end else if (v >= hi) begin
          s1_data_nxt.hi_ex = cfg.n;
        end else begin
          s1_data_nxt.sel   = lbpe_pkg::SEL_CNT;
          s1_data_nxt.mul_a = diff_vl[LB-1:0];
          s1_data_nxt.mul_b = cfg.n;
          s1_data_nxt.den   = diff_hl[LB-1:0];
        end
      end else if (v <= 0) begin
        s1_data_nxt.hi_ex = '0;
      end else if (v >= nn) begin
        s1_data_nxt.hi_ex = cfg.n;
      end else begin
        s1_data_nxt.hi_ex = v[LW-1:0];
      end
    end else begin
      s1_data_nxt.lo_idx = lc;
      s1_data_nxt.hi_ex  = LW'(rc + 1'b1);
      if (v > 0) begin
        if (v >= hi) begin
          s1_data_nxt.hi_ex = cfg.n;
        end else if (hi > 0) begin
          s1_data_nxt.sel     = lbpe_pkg::SEL_RIGHT;
          s1_data_nxt.mul_a   = v[LB-1:0];
          s1_data_nxt.mul_b   = LW'(cfg.n - 1'b1 - rc);
          s1_data_nxt.den     = hi[LB-1:0];
          s1_data_nxt.ceil_up = 1'b1;
        end
      end else if (v < 0) begin
        if (v <= lo) begin
          s1_data_nxt.lo_idx = '0;
        end else if (lo < 0) begin
          s1_data_nxt.sel     = lbpe_pkg::SEL_LEFT;
          s1_data_nxt.mul_a   = neg_v[LB-1:0];
          s1_data_nxt.mul_b   = lc;
          s1_data_nxt.den     = neg_lo[LB-1:0];
          s1_data_nxt.ceil_up = 1'b1;
        end
      end
    end
  end

  always_comb begin
    prod = lbpe_pkg::NUM_W'(s1_data_r.mul_a) * lbpe_pkg::NUM_W'(s1_data_r.mul_b);
    offs = s1_data_r.ceil_up ? (lbpe_pkg::NUM_W'(s1_data_r.den) - 1'b1) : '0;
    s2_data_nxt.sel    = s1_data_r.sel;
    s2_data_nxt.lo_idx = s1_data_r.lo_idx;
    s2_data_nxt.hi_ex  = s1_data_r.hi_ex;
    s2_data_nxt.rem    = prod + offs;
    s2_data_nxt.den    = s1_data_r.den;
    s2_data_nxt.q      = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_data_r <= s1_data_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      s2_data_r <= s2_data_nxt;
    end
  end

endmodule

### hw/rtl/lbpe_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, most significant first.
// ----------------------------------------------------------------------------
module lbpe_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lbpe_pkg::div_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output lbpe_pkg::span_t out_data
);

  localparam int QW = lbpe_pkg::QW;

  logic           stg_valid_r [QW];
  lbpe_pkg::div_t stg_data_r  [QW];
  logic           stg_ready   [QW+1];
  logic           stg_in_valid[QW];
  lbpe_pkg::div_t stg_in_data [QW];

  assign stg_ready[QW] = out_ready;
  assign in_ready      = stg_ready[0];
  assign out_valid     = stg_valid_r[QW-1];

  always_comb begin
    out_data.sel    = stg_data_r[QW-1].sel;
    out_data.lo_idx = stg_data_r[QW-1].lo_idx;
    out_data.hi_ex  = stg_data_r[QW-1].hi_ex;
    out_data.q      = stg_data_r[QW-1].q;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int BIT = QW - 1 - k;
    lbpe_pkg::div_t             d_nxt;
    logic [lbpe_pkg::NUM_W-1:0] sub_val;

    if (k == 0) begin : g_first
      assign stg_in_valid[k] = in_valid;
      assign stg_in_data[k]  = in_data;
    end else begin : g_next
      assign stg_in_valid[k] = stg_valid_r[k-1];
      assign stg_in_data[k]  = stg_data_r[k-1];
    end

    assign stg_ready[k] = !stg_valid_r[k] || stg_ready[k+1];

    always_comb begin
      d_nxt   = stg_in_data[k];
      sub_val = lbpe_pkg::NUM_W'(stg_in_data[k].den) << BIT;
      if (stg_in_data[k].rem >= sub_val) begin
        d_nxt.rem    = stg_in_data[k].rem - sub_val;
        d_nxt.q[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_valid_r[k] <= 1'b0;
      end else if (stg_ready[k]) begin
        stg_valid_r[k] <= stg_in_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (stg_ready[k] && stg_in_valid[k]) begin
        stg_data_r[k] <= d_nxt;
      end
    end
  end

endmodule

### hw/rtl/lbpe_image.sv
// ----------------------------------------------------------------------------
// Shift image builder
// Stage 1 makes the lit-LED mask, stage 2 mirrors it, stage 3 packs bytes
// into shift order and applies the output enable.
// ----------------------------------------------------------------------------
module lbpe_image (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lbpe_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lbpe_pkg::span_t               in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lbpe_pkg::IMG_W-1:0]    out_image,
  output logic [lbpe_pkg::BC_W-1:0]     out_bc
);

  localparam int IW   = lbpe_pkg::IMG_W;
  localparam int LW   = lbpe_pkg::LED_W;
  localparam int SH_W = $clog2(IW + 1);

  logic                  m_valid_r;
  logic [IW-1:0]         m_mask_r;
  logic [IW-1:0]         m_mask_nxt;
  logic                  r_valid_r;
  logic [IW-1:0]         r_mask_r;
  logic [IW-1:0]         r_mask_nxt;
  logic                  p_valid_r;
  logic [IW-1:0]         p_image_r;
  logic [IW-1:0]         p_image_nxt;
  logic [lbpe_pkg::BC_W-1:0] p_bc_r;
  logic                  m_ready;
  logic                  r_ready;
  logic                  p_ready;
  logic [LW-1:0]         lo_f;
  logic [LW-1:0]         hi_f;
  logic [IW-1:0]         rev;
  logic [IW-1:0]         brev;
  logic [SH_W-1:0]       mir_sh;
  logic [lbpe_pkg::BC_W+2:0] pack_sh;

  function automatic logic [IW-1:0] therm(input logic [LW-1:0] k);
    logic [IW-1:0] t;
    for (int i = 0; i < IW; i++) begin
      t[i] = (i < int'(k));
    end
    return t;
  endfunction

  assign p_ready   = !p_valid_r || out_ready;
  assign r_ready   = !r_valid_r || p_ready;
  assign m_ready   = !m_valid_r || r_ready;
  assign in_ready  = m_ready;
  assign out_valid = p_valid_r;
  assign out_image = p_image_r;
  assign out_bc    = p_bc_r;

  always_comb begin
    lo_f = in_data.lo_idx;
    hi_f = in_data.hi_ex;
    case (in_data.sel)
      lbpe_pkg::SEL_CNT:   hi_f = in_data.q;
      lbpe_pkg::SEL_RIGHT: hi_f = LW'(in_data.hi_ex + in_data.q);
      lbpe_pkg::SEL_LEFT:  lo_f = LW'(in_data.lo_idx - in_data.q);
      default: ;
    endcase
    m_mask_nxt = therm(hi_f) & ~therm(lo_f);
  end

  // Mirror inside the fitted LEDs: full reversal, then drop the unused top
  always_comb begin
    for (int i = 0; i < IW; i++) begin
      rev[i] = m_mask_r[IW-1-i];
    end
    mir_sh     = SH_W'(IW) - SH_W'(cfg.n);
    r_mask_nxt = cfg.reverse_order ? (rev >> mir_sh) : m_mask_r;
  end

  // LED byte j goes to shift byte bc-1-j
  always_comb begin
    for (int b = 0; b < lbpe_pkg::NBYTES; b++) begin
      brev[8*b +: 8] = r_mask_r[8*(lbpe_pkg::NBYTES-1-b) +: 8];
    end
    pack_sh     = {lbpe_pkg::BC_W'(lbpe_pkg::NBYTES) - cfg.bc, 3'b000};
    p_image_nxt = cfg.output_enable ? (brev >> pack_sh) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      r_valid_r <= 1'b0;
      p_valid_r <= 1'b0;
    end else begin
      if (m_ready) begin
        m_valid_r <= in_valid;
      end
      if (r_ready) begin
        r_valid_r <= m_valid_r;
      end
      if (p_ready) begin
        p_valid_r <= r_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready && in_valid) begin
      m_mask_r <= m_mask_nxt;
    end
    if (r_ready && m_valid_r) begin
      r_mask_r <= r_mask_nxt;
    end
    if (p_ready && r_valid_r) begin
      p_image_r <= p_image_nxt;
      p_bc_r    <= cfg.bc;
    end
  end

endmodule

### hw/rtl/led_bargraph_pattern_encoder_unit.sv
// ----------------------------------------------------------------------------
// LED bar-graph pattern encoder
// Turns a signed level into the shift-register image for an LED bar.
// ----------------------------------------------------------------------------
// Takes one level per cycle unless the result side holds the pipeline, and
// returns its image after operand selection and the scaling multiply, the
// bit-per-stage divider that scales the level to an LED count, and the stages
// that build, mirror and pack the mask, the last of which is the output
// register. Back-pressure from the result side stalls only the stages that
// hold data; empty stages keep filling. Write the configuration registers
// only while no transfer is in flight.
module led_bargraph_pattern_encoder_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  lbpe_in_if.sink                       in_ch,
  lbpe_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lbpe_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [lbpe_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [lbpe_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  lbpe_pkg::cfg_t  cfg;
  logic            prep_valid;
  logic            prep_ready;
  lbpe_pkg::div_t  prep_data;
  logic            div_valid;
  logic            div_ready;
  lbpe_pkg::span_t div_data;

  lbpe_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lbpe_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_level  (in_ch.level),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_data  (prep_data)
  );

  lbpe_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  lbpe_image u_image (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_data   (div_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_image (out_ch.shift_image),
    .out_bc    (out_ch.byte_count)
  );

  // A free result side must never hold off the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while result side ready");

  a_bc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.byte_count != '0) &&
                     (out_ch.byte_count <= lbpe_pkg::BC_W'(lbpe_pkg::NBYTES)))
    else $error("byte count out of range");

  a_enable_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_psel && cfg_penable && cfg_pwrite &&
     cfg_paddr[lbpe_pkg::ADDR_W-1:2] == lbpe_pkg::REG_ENABLE)
    |=> (cfg.output_enable == $past(cfg_pwdata[0])))
    else $error("output enable write lost");

endmodule
